/* src/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants of the Sobel RGB edge magnitude block.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FW_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam int GRAD_W     = 12;
    localparam int ABS_W      = 10;
    localparam int SUM_W      = 21;
    localparam int ACC_W      = 22;
    localparam int ROOT_W     = 11;
    localparam int ROOT_STEPS = 11;
    localparam int STEP_W     = 4;
    localparam logic [ROOT_W:0] EDGE_MAX = 12'd255;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_blue;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_red;
        logic [PIX_W-1:0] edge_green;
        logic [PIX_W-1:0] edge_blue;
        logic             last_of_frame;
    } out_word_t;

    typedef struct packed {
        logic produce;
        logic last;
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
    } win_mask_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_START,
        ST_ROOT
    } sed_state_t;

endpackage

/* src/sobel_edge_magnitude_rgb_core.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// 3x3 Sobel gradient magnitude per colour channel over a raster stream.
//
// Pixels enter on the s_ channel as words in raster order; results leave on
// the m_ channel. Each result belongs to the pixel width+1 positions back,
// so a frame is flushed with width+1 drain words (opcode 1). The result of
// the frame's last pixel carries last_of_frame, after which a new frame
// starts. A word that gives a result passes through the window update and
// store write-back, the gradients, loading the root unit, resolving one
// root bit per cycle and registering the result. The next word is accepted
// only once that result is registered, so the block takes no new word while
// one is in flight. Words that give no result free the input after the
// window update. A finished result waits in the output register, and a
// stalled receiver holds the block only when a second result is ready.
// Reset clears the counters and the window and loads width 640, height 480;
// the line store needs no clearing. Writes to the width or height restart the frame.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_WIDTH  = sed_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sed_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sed_pkg::in_word_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sed_pkg::out_word_t              m_data,
    input  logic                            cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sed_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int DW = 6 * PIX_W;

    sed_state_t state_reg, state_next;

    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   w_used;
    logic [RW-1:0]   h_used;
    logic [CW-1:0]   col_eff;
    logic [RW:0]     h_plus;
    logic            c_pos;

    in_word_t  in_reg;
    rgb_t      px;
    rgb_t      win_reg [3][3];
    win_mask_t mask_reg, mask_next;

    logic [DW-1:0] rd_data;
    rgb_t          rd_upper, rd_middle;
    logic          mem_we;

    logic [2:0][2:0][PIX_W-1:0] ch_win [3];
    logic [SUM_W-1:0]           sq_sum [3];
    logic [SUM_W-1:0]           sum_reg [3];
    logic [PIX_W-1:0]           mag [3];
    logic [2:0]                 root_done;
    logic                       root_start;

    logic      m_valid_reg;
    out_word_t m_data_reg;
    logic      emit;

    always_comb begin
        if (width_reg == '0) begin
            w_used = CW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_used = CW'(MAX_WIDTH);
        end else begin
            w_used = CW'(width_reg);
        end
        if (height_reg == '0) begin
            h_used = RW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_used = RW'(MAX_HEIGHT);
        end else begin
            h_used = RW'(height_reg);
        end
        col_eff = (col_reg < w_used) ? col_reg : '0;
        h_plus  = {1'b0, h_used} + 1'b1;
        c_pos   = (col_eff != '0);
    end

    sed_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (DW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (col_eff[AW-1:0]),
        .wr_data ({rd_middle, px}),
        .rd_addr (col_eff[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_upper  = rd_data[DW-1:DW/2];
    assign rd_middle = rd_data[DW/2-1:0];
    assign mem_we    = (state_reg == ST_LOAD);

    always_comb begin
        px = '0;
        if (({1'b0, row_reg} < {1'b0, h_used}) && !in_reg.opcode) begin
            px = '{red: in_reg.pixel_red, green: in_reg.pixel_green,
                   blue: in_reg.pixel_blue};
        end
    end

    always_comb begin
        mask_next.produce   = c_pos ? (row_reg >= RW'(1) && row_reg <= h_used)
                                    : (row_reg >= RW'(2) && {1'b0, row_reg} <= h_plus);
        mask_next.last      = !c_pos && ({1'b0, row_reg} == h_plus);
        mask_next.row_top   = c_pos ? (row_reg >= RW'(2)) : (row_reg >= RW'(3));
        mask_next.row_bot   = c_pos ? (row_reg < h_used) : (row_reg <= h_used);
        mask_next.col_left  = c_pos ? (col_eff >= CW'(2)) : (w_used >= CW'(2));
        mask_next.col_right = c_pos;
        if (mask_next.produce && mask_next.last) begin
            col_next = '0;
            row_next = '0;
        end else if (col_eff + 1'b1 >= w_used) begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end else begin
            col_next = col_eff + 1'b1;
            row_next = row_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                ch_win[0][k][a] = win_reg[a][k].red;
                ch_win[1][k][a] = win_reg[a][k].green;
                ch_win[2][k][a] = win_reg[a][k].blue;
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        sed_grad u_grad (
            .win    (ch_win[c]),
            .mask   (mask_reg),
            .sq_sum (sq_sum[c])
        );

        sed_root u_root (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (root_start),
            .sq_sum    (sum_reg[c]),
            .done      (root_done[c]),
            .magnitude (mag[c])
        );
    end

    assign root_start = (state_reg == ST_START);
    assign emit       = (state_reg == ST_ROOT) && (&root_done)
                      && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = mask_next.produce ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[a][k] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == CFG_FRAME_WIDTH) begin
                width_reg <= cfg_data[FW_W-1:0];
                col_reg   <= '0;
                row_reg   <= '0;
            end else if (cfg_we && cfg_index == CFG_FRAME_HEIGHT) begin
                height_reg <= cfg_data[FH_W-1:0];
                col_reg    <= '0;
                row_reg    <= '0;
            end else if (state_reg == ST_LOAD) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (state_reg == ST_LOAD) begin
                win_reg[2] <= win_reg[1];
                win_reg[1] <= win_reg[0];
                win_reg[0][0] <= rd_upper;
                win_reg[0][1] <= rd_middle;
                win_reg[0][2] <= px;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_LOAD) begin
            mask_reg <= mask_next;
        end
        if (state_reg == ST_GRAD) begin
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= sq_sum[c];
            end
        end
        if (emit) begin
            m_data_reg.edge_red      <= mag[0];
            m_data_reg.edge_green    <= mag[1];
            m_data_reg.edge_blue     <= mag[2];
            m_data_reg.last_of_frame <= mask_reg.last;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* src/sed_line_mem.sv */
// ----------------------------------------------------------------------------
// sed_line_mem
// Line store holding the two previous rows per column, one read port and
// one write port, registered read data.
// ----------------------------------------------------------------------------
module sed_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 48
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sed_grad.sv */
// ----------------------------------------------------------------------------
// sed_grad
// Sobel Gx and Gy of one channel over the masked 3x3 window, returning
// the sum of squares.
// ----------------------------------------------------------------------------
module sed_grad (
    input  logic [2:0][2:0][sed_pkg::PIX_W-1:0] win,
    input  sed_pkg::win_mask_t                   mask,
    output logic [sed_pkg::SUM_W-1:0]            sq_sum
);
    import sed_pkg::*;

    logic signed [GRAD_W-1:0] v [3][3];
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gx_abs;
    logic signed [GRAD_W-1:0] gy_abs;
    logic [2*ABS_W-1:0]       sq_x;
    logic [2*ABS_W-1:0]       sq_y;
    logic [2:0]               row_ok;
    logic [2:0]               age_ok;

    always_comb begin
        row_ok = {mask.row_bot, 1'b1, mask.row_top};
        age_ok = {mask.col_left, 1'b1, mask.col_right};
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                v[k][a] = (row_ok[k] && age_ok[a])
                        ? $signed({{(GRAD_W-PIX_W){1'b0}}, win[k][a]})
                        : '0;
            end
        end
        gx = (v[0][0] - v[0][2]) + GRAD_W'(2) * (v[1][0] - v[1][2])
           + (v[2][0] - v[2][2]);
        gy = (v[2][2] + GRAD_W'(2) * v[2][1] + v[2][0])
           - (v[0][2] + GRAD_W'(2) * v[0][1] + v[0][0]);
        gx_abs = gx[GRAD_W-1] ? -gx : gx;
        gy_abs = gy[GRAD_W-1] ? -gy : gy;
        sq_x = gx_abs[ABS_W-1:0] * gx_abs[ABS_W-1:0];
        sq_y = gy_abs[ABS_W-1:0] * gy_abs[ABS_W-1:0];
        sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
    end

endmodule

/* src/sed_root.sv */
// ----------------------------------------------------------------------------
// sed_root
// Iterative integer square root, one result bit per cycle, rounded to
// nearest and clamped to 255.
// ----------------------------------------------------------------------------
module sed_root (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sed_pkg::SUM_W-1:0]   sq_sum,
    output logic                        done,
    output logic [sed_pkg::PIX_W-1:0]   magnitude
);
    import sed_pkg::*;

    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  res_reg, res_next;
    logic [ACC_W-1:0]  bit_reg, bit_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0]  trial;
    logic [ROOT_W:0]   rounded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    always_comb begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        trial    = res_reg + bit_reg;
        if (start) begin
            rem_next = {1'b0, sq_sum};
            res_next = '0;
            bit_next = ACC_W'(1) << (SUM_W - 1);
            cnt_next = STEP_W'(ROOT_STEPS);
        end else if (cnt_reg != '0) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb begin
        rounded = {1'b0, res_reg[ROOT_W-1:0]}
                + {{ROOT_W{1'b0}}, (rem_reg > {{(ACC_W-ROOT_W){1'b0}}, res_reg[ROOT_W-1:0]})};
        magnitude = (rounded > EDGE_MAX) ? EDGE_MAX[PIX_W-1:0] : rounded[PIX_W-1:0];
    end

    assign done = (cnt_reg == '0);

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Sobel RGB edge magnitude testbench
// Streams RGB frames of many sizes into the core. Directed frames come first,
// then random ones, with drain words after each random frame sent in full. A scoreboard predicts
// every result from its own line stores and window, then checks each result
// word field by field. Both channels idle at random, and one long receiver
// hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;
    import sed_pkg::*;

    class edge_scoreboard;
        rgb_t          upper_row[MAX_WIDTH_DEF];
        rgb_t          middle_row[MAX_WIDTH_DEF];
        rgb_t          win[3][3];
        int unsigned   width_reg, height_reg, col_cnt, row_cnt;
        out_word_t     expected[$];
        int            failures;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[a, r]) win[a][r] = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_cnt    = 0;
            row_cnt    = 0;
            failures   = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH) begin
                width_reg = val[FW_W-1:0];
            end else if (idx == CFG_FRAME_HEIGHT) begin
                height_reg = val[FH_W-1:0];
            end else begin
                return;
            end
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function int chan(rgb_t p, int ch);
            case (ch)
                0: return p.red;
                1: return p.green;
                default: return p.blue;
            endcase
        endfunction

        function logic [PIX_W-1:0] magnitude(int gx, int gy);
            int unsigned s, n, t;
            s = gx * gx + gy * gy;
            n = 0;
            for (int b = 11; b >= 0; b--) begin
                t = n | (1 << b);
                if (t * t <= s) n = t;
            end
            if (s > n * n + n) n++;
            return (n > 255) ? 8'd255 : n[7:0];
        endfunction

        function void note_input(in_word_t w);
            int unsigned      wd, ht, col, row;
            int               rc, cc, gx, gy;
            rgb_t             px;
            bit               rv[3], cv[3], last;
            int               v[3][3];
            logic [PIX_W-1:0] e[3];
            out_word_t        res;
            wd  = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_reg);
            ht  = (height_reg < 1) ? 1 :
                  (height_reg > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : height_reg);
            col = (col_cnt < wd) ? col_cnt : 0;
            row = row_cnt;
            px  = '0;
            if (row < ht && w.opcode == 1'b0) begin
                px = '{w.pixel_red, w.pixel_green, w.pixel_blue};
            end
            for (int r = 0; r < 3; r++) begin
                win[2][r] = win[1][r];
                win[1][r] = win[0][r];
            end
            win[0][0] = upper_row[col];
            win[0][1] = middle_row[col];
            win[0][2] = px;
            upper_row[col]  = middle_row[col];
            middle_row[col] = px;
            if (col >= 1) begin
                rc = int'(row) - 1;
                cc = int'(col) - 1;
            end else begin
                rc = int'(row) - 2;
                cc = int'(wd) - 1;
            end
            if (rc >= 0 && rc < int'(ht)) begin
                last  = (rc == int'(ht) - 1) && (cc == int'(wd) - 1);
                rv[0] = rc >= 1;
                rv[1] = 1'b1;
                rv[2] = rc + 1 < int'(ht);
                cv[2] = cc >= 1;
                cv[1] = 1'b1;
                cv[0] = cc + 1 < int'(wd);
                for (int ch = 0; ch < 3; ch++) begin
                    for (int k = 0; k < 3; k++) begin
                        for (int j = 0; j < 3; j++) begin
                            v[k][j] = (rv[k] && cv[2-j]) ? chan(win[2-j][k], ch) : 0;
                        end
                    end
                    gx = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
                    gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
                    e[ch] = magnitude(gx, gy);
                end
                res.edge_red      = e[0];
                res.edge_green    = e[1];
                res.edge_blue     = e[2];
                res.last_of_frame = last;
                expected.push_back(res);
                if (last) begin
                    col_cnt = 0;
                    row_cnt = 0;
                    return;
                end
            end
            col++;
            if (col >= wd) begin
                col = 0;
                row++;
            end
            col_cnt = col;
            row_cnt = row;
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = expected.pop_front();
            if (got.edge_red !== want.edge_red || got.edge_green !== want.edge_green ||
                got.edge_blue !== want.edge_blue ||
                got.last_of_frame !== want.last_of_frame) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected r=%0d g=%0d b=%0d last=%0b,",
                             want.edge_red, want.edge_green, want.edge_blue,
                             want.last_of_frame,
                             " got r=%0d g=%0d b=%0d last=%0b",
                             got.edge_red, got.edge_green, got.edge_blue, got.last_of_frame);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3000000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    edge_scoreboard sb;
    bit             calm;
    bit             hold_req;
    int             words_sent;
    int unsigned    cycles;

    sobel_edge_magnitude_rgb_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        int held;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                held = 0;
                while (held < 400) begin
                    @(negedge aclk);
                    held++;
                end
            end
            m_ready = calm || ($urandom_range(99) >= 35);
        end
    end

    task automatic send_word(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        s_data  = '{op, r, g, b};
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
        if (!calm && $urandom_range(99) < 35) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (sb.expected.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.configure(idx, val);
    endtask

    task automatic random_pixel();
        logic op;
        op = ($urandom_range(99) < 5);
        send_word(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    task automatic run_frame(int w, int h, bit full);
        int n;
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        n = full ? w * h : $urandom_range(1, w * h);
        repeat (n) random_pixel();
        if (full) begin
            repeat (w + 1) send_word($urandom_range(99) < 85, 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int w, h;
        sb         = new();
        calm       = 1'b0;
        hold_req   = 1'b0;
        words_sent = 0;
        cycles     = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: 3x2 frame with extremes, drain inside the frame
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        send_word(1'b0, 8'hFF, 8'h00, 8'hFF);
        send_word(1'b0, 8'h00, 8'hFF, 8'h00);
        send_word(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b0, 8'h00, 8'h00, 8'h00);
        send_word(1'b0, 8'hFF, 8'h00, 8'h55);
        repeat (2) send_word(1'b1, 8'hAA, 8'h55, 8'hFF);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        // width and height zero give a 1x1 frame
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        send_word(1'b0, 8'h12, 8'h34, 8'h56);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        // ignored register indexes, then restart mid-frame
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        repeat (6) random_pixel();
        write_reg(2'd2, '1);
        write_reg(2'd3, 13'h0AAA);
        repeat (3) random_pixel();
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        repeat (17) random_pixel();
        // tallest frame, partly sent
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        repeat (20) random_pixel();
        // widest frame, partly sent
        write_reg(CFG_FRAME_WIDTH, 13'hFFF);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        repeat (30) random_pixel();

        words_sent = 0;
        hold_req   = 1'b1;
        run_frame(40, 8, 1'b1);
        while (words_sent < 2000) begin
            calm = (words_sent > 700 && words_sent < 1100);
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            run_frame(w, h, $urandom_range(9) != 0);
        end
        calm = 1'b0;
        settle();
        if (sb.failures == 0 && sb.expected.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

/* sobel_edge_magnitude_rgb_core.f */
src/sed_pkg.sv
src/sed_line_mem.sv
src/sed_grad.sv
src/sed_root.sv
src/sobel_edge_magnitude_rgb_core.sv
dv/testbench.sv
